// ----- rtl/kabf_pkg.sv -----
package kabf_pkg;

	localparam int DataW = 32;
	localparam int RegW = 31;
	localparam int FracW = 20;
	localparam int AddrW = 4;

	localparam logic signed [DataW-1:0] QMax = 32'sh7fff_ffff;
	localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;
	localparam logic signed [DataW-1:0] QOne = 32'sh0010_0000;

	localparam logic [1:0] RegNoiseAngle = 2'd0;
	localparam logic [1:0] RegNoiseBias = 2'd1;
	localparam logic [1:0] RegNoiseMeas = 2'd2;
	localparam logic [1:0] RegTimeStep = 2'd3;

	localparam logic [RegW-1:0] RstNoiseAngle = 31'd5243;
	localparam logic [RegW-1:0] RstNoiseBias = 31'd31457;
	localparam logic [RegW-1:0] RstNoiseMeas = 31'd31457;
	localparam logic [RegW-1:0] RstTimeStep = 31'd10486;

	// Request to a serial arithmetic unit and its answer.
	typedef struct packed {
		logic start;
		logic signed [DataW-1:0] a;
		logic signed [DataW-1:0] b;
	} op_req_t;

	typedef struct packed {
		logic done;
		logic signed [DataW-1:0] res;
	} op_rsp_t;

	function automatic logic signed [DataW-1:0] sat_add(
		input logic signed [DataW-1:0] x,
		input logic signed [DataW-1:0] y
	);
		logic signed [DataW:0] s;
		s = {x[DataW-1], x} + {y[DataW-1], y};
		if (s[DataW] != s[DataW-1]) begin
			return s[DataW] ? QMin : QMax;
		end
		return s[DataW-1:0];
	endfunction

	function automatic logic signed [DataW-1:0] sat_sub(
		input logic signed [DataW-1:0] x,
		input logic signed [DataW-1:0] y
	);
		logic signed [DataW:0] s;
		s = {x[DataW-1], x} - {y[DataW-1], y};
		if (s[DataW] != s[DataW-1]) begin
			return s[DataW] ? QMin : QMax;
		end
		return s[DataW-1:0];
	endfunction

endpackage

// ----- rtl/kabf_if.sv -----
interface kabf_sample_if import kabf_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DataW-1:0] measured_angle;
	logic signed [DataW-1:0] measured_rate;

	modport source(output valid, measured_angle, measured_rate, input ready);
	modport sink(input valid, measured_angle, measured_rate, output ready);
endinterface

interface kabf_result_if import kabf_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DataW-1:0] filtered_angle;

	modport source(output valid, filtered_angle, input ready);
	modport sink(input valid, filtered_angle, output ready);
endinterface

// ----- rtl/kalman_angle_bias_filter_unit.sv -----
// Each sample runs ten products on one bit-serial multiplier and two quotients on one
// bit-serial divider, then registers the result for output; the quotients are skipped
// when the innovation variance is not positive. A new sample is taken while the last
// result waits. Reset (arst_n low, asynchronous): registers to defaults, estimates to
// zero, covariance to identity.
module kalman_angle_bias_filter_unit import kabf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	kabf_sample_if.sink       sample,
	kabf_result_if.source     result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [AddrW-1:0]  paddr,
	input  logic [DataW-1:0]  pwdata,
	output logic [DataW-1:0]  prdata,
	output logic              pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M_ANG,
		ST_M_T,
		ST_M_PAA,
		ST_M_PBB,
		ST_DIV0,
		ST_DIV1,
		ST_M_A,
		ST_M_B,
		ST_M_C,
		ST_M_D,
		ST_M_E,
		ST_M_F,
		ST_FIN
	} state_t;

	state_t state_q;
	logic go_q;
	logic [RegW-1:0] qa_q, qb_q, rm_q, dt_q;
	logic signed [DataW-1:0] ang_q, bias_q, paa_q, pab_q, pba_q, pbb_q;
	logic signed [DataW-1:0] meas_q, rate_q, t_q, s_q, k0_q, k1_q, y_q;
	logic out_valid_q;
	logic signed [DataW-1:0] out_angle_q;

	op_req_t mul_req, div_req;
	op_rsp_t mul_rsp, div_rsp;
	logic is_mul;
	logic s_pos;
	logic signed [DataW-1:0] dt_s, inner;
	logic cfg_wr;

	kabf_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	kabf_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign dt_s = $signed({1'b0, dt_q});
	assign inner = sat_add(sat_sub(sat_sub(t_q, pab_q), pba_q), $signed({1'b0, qa_q}));
	assign s_pos = !s_q[DataW-1] && (s_q != '0);

	assign is_mul = (state_q == ST_M_ANG) || (state_q == ST_M_T) || (state_q == ST_M_PAA) ||
		(state_q == ST_M_PBB) || (state_q == ST_M_A) || (state_q == ST_M_B) ||
		(state_q == ST_M_C) || (state_q == ST_M_D) || (state_q == ST_M_E) ||
		(state_q == ST_M_F);

	always_comb begin
		mul_req.start = is_mul && !go_q;
		mul_req.a = dt_s;
		mul_req.b = dt_s;
		case (state_q)
			ST_M_ANG: mul_req.b = sat_sub(rate_q, bias_q);
			ST_M_T:   mul_req.b = pbb_q;
			ST_M_PAA: mul_req.b = inner;
			ST_M_PBB: mul_req.a = $signed({1'b0, qb_q});
			ST_M_A: begin
				mul_req.a = k0_q;
				mul_req.b = y_q;
			end
			ST_M_B: begin
				mul_req.a = k1_q;
				mul_req.b = y_q;
			end
			ST_M_C: begin
				mul_req.a = k1_q;
				mul_req.b = paa_q;
			end
			ST_M_D: begin
				mul_req.a = k1_q;
				mul_req.b = pab_q;
			end
			ST_M_E: begin
				mul_req.a = k0_q;
				mul_req.b = paa_q;
			end
			ST_M_F: begin
				mul_req.a = k0_q;
				mul_req.b = pab_q;
			end
			default: mul_req.b = dt_s;
		endcase
	end

	always_comb begin
		div_req.start = ((state_q == ST_DIV0) && s_pos && !go_q) ||
			((state_q == ST_DIV1) && !go_q);
		div_req.a = (state_q == ST_DIV1) ? pba_q : paa_q;
		div_req.b = s_q;
	end

	assign sample.ready = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.filtered_angle = out_angle_q;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[AddrW-1:2])
			RegNoiseAngle: prdata = {1'b0, qa_q};
			RegNoiseBias:  prdata = {1'b0, qb_q};
			RegNoiseMeas:  prdata = {1'b0, rm_q};
			RegTimeStep:   prdata = {1'b0, dt_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= RstNoiseAngle;
			qb_q <= RstNoiseBias;
			rm_q <= RstNoiseMeas;
			dt_q <= RstTimeStep;
		end else if (cfg_wr) begin
			case (paddr[AddrW-1:2])
				RegNoiseAngle: qa_q <= pwdata[RegW-1:0];
				RegNoiseBias:  qb_q <= pwdata[RegW-1:0];
				RegNoiseMeas:  rm_q <= pwdata[RegW-1:0];
				RegTimeStep:   dt_q <= pwdata[RegW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q <= 1'b0;
			out_valid_q <= 1'b0;
			ang_q <= '0;
			bias_q <= '0;
			paa_q <= QOne;
			pab_q <= '0;
			pba_q <= '0;
			pbb_q <= QOne;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (mul_req.start || div_req.start) begin
				go_q <= 1'b1;
			end
			if (mul_rsp.done || div_rsp.done) begin
				go_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						meas_q <= sample.measured_angle;
						rate_q <= sample.measured_rate;
						state_q <= ST_M_ANG;
					end
				end
				ST_M_ANG: begin
					if (mul_rsp.done) begin
						ang_q <= sat_add(ang_q, mul_rsp.res);
						state_q <= ST_M_T;
					end
				end
				ST_M_T: begin
					if (mul_rsp.done) begin
						t_q <= mul_rsp.res;
						state_q <= ST_M_PAA;
					end
				end
				ST_M_PAA: begin
					if (mul_rsp.done) begin
						paa_q <= sat_add(paa_q, mul_rsp.res);
						pab_q <= sat_sub(pab_q, t_q);
						pba_q <= sat_sub(pba_q, t_q);
						state_q <= ST_M_PBB;
					end
				end
				ST_M_PBB: begin
					if (mul_rsp.done) begin
						pbb_q <= sat_add(pbb_q, mul_rsp.res);
						s_q <= sat_add(paa_q, $signed({1'b0, rm_q}));
						state_q <= ST_DIV0;
					end
				end
				ST_DIV0: begin
					if (!s_pos) begin
						// No usable innovation variance: both gains are zero.
						k0_q <= '0;
						k1_q <= '0;
						y_q <= sat_sub(meas_q, ang_q);
						state_q <= ST_M_A;
					end else if (div_rsp.done) begin
						k0_q <= div_rsp.res;
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						k1_q <= div_rsp.res;
						y_q <= sat_sub(meas_q, ang_q);
						state_q <= ST_M_A;
					end
				end
				ST_M_A: begin
					if (mul_rsp.done) begin
						ang_q <= sat_add(ang_q, mul_rsp.res);
						state_q <= ST_M_B;
					end
				end
				ST_M_B: begin
					if (mul_rsp.done) begin
						bias_q <= sat_add(bias_q, mul_rsp.res);
						state_q <= ST_M_C;
					end
				end
				// The bias row is corrected first so that it still sees the old angle row.
				ST_M_C: begin
					if (mul_rsp.done) begin
						pba_q <= sat_sub(pba_q, mul_rsp.res);
						state_q <= ST_M_D;
					end
				end
				ST_M_D: begin
					if (mul_rsp.done) begin
						pbb_q <= sat_sub(pbb_q, mul_rsp.res);
						state_q <= ST_M_E;
					end
				end
				ST_M_E: begin
					if (mul_rsp.done) begin
						paa_q <= sat_sub(paa_q, mul_rsp.res);
						state_q <= ST_M_F;
					end
				end
				ST_M_F: begin
					if (mul_rsp.done) begin
						pab_q <= sat_sub(pab_q, mul_rsp.res);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_angle_q <= ang_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> state_q != ST_IDLE)
		else $error("sample request taken but sequencer stayed idle");
	a_mul_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> go_q && is_mul)
		else $error("multiplier answered without an open request");
	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> go_q && (state_q == ST_DIV0 || state_q == ST_DIV1))
		else $error("divider answered outside the gain phase");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req.start && div_req.start))
		else $error("both arithmetic units started together");
`endif

endmodule

// ----- rtl/kabf_mul.sv -----
module kabf_mul import kabf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  op_req_t req,
	output op_rsp_t rsp
);

	typedef enum logic [1:0] {
		MS_IDLE,
		MS_RUN,
		MS_SIGN,
		MS_ROUND
	} mstate_t;

	mstate_t state_q;
	logic [4:0] cnt_q;
	logic [DataW-1:0] mcand_q;
	logic [DataW-1:0] mplier_q;
	logic [2*DataW-1:0] acc_q;
	logic neg_q;
	logic done_q;
	logic signed [DataW-1:0] res_q;

	logic [DataW:0] psum;
	logic signed [2*DataW-1:0] rnd;
	logic signed [2*DataW-FracW-1:0] quo;
	logic ovf;

	assign psum = {1'b0, acc_q[2*DataW-1:DataW]} + (mplier_q[0] ? {1'b0, mcand_q} : '0);
	assign rnd = $signed(acc_q) + $signed({{(2*DataW-FracW){1'b0}}, 1'b1, {(FracW-1){1'b0}}});
	assign quo = rnd[2*DataW-1:FracW];
	// Out of range when the bits above the result width are not a plain sign extension.
	assign ovf = (quo[2*DataW-FracW-1:DataW-1] != '0) && (quo[2*DataW-FracW-1:DataW-1] != '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MS_IDLE: begin
					if (req.start) begin
						mcand_q <= req.a[DataW-1] ? DataW'(-req.a) : DataW'(req.a);
						mplier_q <= req.b[DataW-1] ? DataW'(-req.b) : DataW'(req.b);
						neg_q <= req.a[DataW-1] ^ req.b[DataW-1];
						acc_q <= '0;
						cnt_q <= '0;
						state_q <= MS_RUN;
					end
				end
				MS_RUN: begin
					acc_q <= {psum, acc_q[DataW-1:1]};
					mplier_q <= mplier_q >> 1;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= MS_SIGN;
					end
				end
				MS_SIGN: begin
					if (neg_q) begin
						acc_q <= -acc_q;
					end
					state_q <= MS_ROUND;
				end
				MS_ROUND: begin
					if (ovf) begin
						res_q <= quo[2*DataW-FracW-1] ? QMin : QMax;
					end else begin
						res_q <= quo[DataW-1:0];
					end
					done_q <= 1'b1;
					state_q <= MS_IDLE;
				end
				default: begin
					state_q <= MS_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;

endmodule

// ----- rtl/kabf_div.sv -----
module kabf_div import kabf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  op_req_t req,
	output op_rsp_t rsp
);

	localparam int QuoW = DataW + FracW;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_RUN,
		DS_FIX
	} dstate_t;

	dstate_t state_q;
	logic [5:0] cnt_q;
	logic [QuoW-1:0] dvd_q;
	logic [DataW:0] rem_q;
	logic [DataW-1:0] den_q;
	logic neg_q;
	logic done_q;
	logic signed [DataW-1:0] res_q;

	logic [DataW:0] trial;
	logic fits;
	logic [DataW:0] diff;

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	assign trial = {rem_q[DataW-1:0], dvd_q[QuoW-1]};
	assign fits = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DS_IDLE: begin
					if (req.start) begin
						neg_q <= req.a[DataW-1];
						dvd_q <= {(req.a[DataW-1] ? DataW'(-req.a) : DataW'(req.a)),
							{FracW{1'b0}}};
						den_q <= req.b;
						rem_q <= '0;
						cnt_q <= '0;
						state_q <= DS_RUN;
					end
				end
				DS_RUN: begin
					rem_q <= fits ? diff : trial;
					dvd_q <= {dvd_q[QuoW-2:0], fits};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(QuoW - 1)) begin
						state_q <= DS_FIX;
					end
				end
				DS_FIX: begin
					if (!neg_q) begin
						res_q <= (dvd_q[QuoW-1:DataW-1] != '0) ? QMax : dvd_q[DataW-1:0];
					end else if ((dvd_q[QuoW-1:DataW] != '0) ||
							(dvd_q[DataW-1] && (dvd_q[DataW-2:0] != '0))) begin
						res_q <= QMin;
					end else begin
						res_q <= -dvd_q[DataW-1:0];
					end
					done_q <= 1'b1;
					state_q <= DS_IDLE;
				end
				default: begin
					state_q <= DS_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;

endmodule
